// ===== rtl/wots_chain_length_digits_unit_defines.svh =====
// assertion macros for the base-w chain length digit unit
// used by the port checker; needs clk and rst_n in the including scope
`ifndef WOTS_CHAIN_LENGTH_DIGITS_UNIT_DEFINES_SVH
`define WOTS_CHAIN_LENGTH_DIGITS_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define WCL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define WCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wcl_pkg.sv =====
// shared types, constants and helpers for the chain length digit unit
// no dependencies
package wcl_pkg;

    localparam int BYTE_W        = 8;
    localparam int BYTE_ROUND    = 7;
    localparam int WIN_W         = 24;
    localparam int POS_W         = 7;
    localparam int LEN2_W        = 5;
    localparam int LEN2_MAX      = 16;
    localparam int IDX_W         = 10;
    localparam int MB_W          = 7;
    localparam int CS_W          = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_LOG_W_SELECT    = 2'd0;
    localparam logic [1:0] CFG_MESSAGE_BYTES   = 2'd1;
    localparam logic [1:0] CFG_CHECKSUM_DIGITS = 2'd2;

    // one classified byte on its way from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [1:0]        lws;
        logic              msg_end;
        logic [LEN2_W-1:0] len2;
        logic [WIN_W-1:0]  csum_win;
        logic [POS_W-1:0]  pos;
    } wcl_entry_t;

    // bits per digit
    function automatic logic [3:0] digit_bits(input logic [1:0] lws);
        digit_bits = 4'd1 << lws;
    endfunction

    // low mask of one digit
    function automatic logic [7:0] digit_mask(input logic [1:0] lws);
        logic [7:0] m;
        unique case (lws)
            2'd0: m = 8'h01;
            2'd1: m = 8'h03;
            2'd2: m = 8'h0F;
            default: m = 8'hFF;
        endcase
        digit_mask = m;
    endfunction

endpackage

// ===== rtl/wcl_front.sv =====
// front end: configuration registers, byte counting, checksum and classification
// depends on wcl_pkg
module wcl_front
    import wcl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [MB_W-1:0]  cfg_data,
    input  logic [7:0]       msg_byte,
    input  logic             push,
    input  logic             q_full,
    output logic             q_push,
    output wcl_entry_t       q_entry
);

    logic [1:0]        lws_reg;
    logic [MB_W-1:0]   mb_reg;
    logic [LEN2_W-1:0] cd_reg;
    logic [MB_W-1:0]   bc_reg, bc_next;
    logic [CS_W-1:0]   cs_reg, cs_next;

    logic [7:0]        nb;
    logic [CS_W-1:0]   inc;
    logic [CS_W-1:0]   cs_sum;
    logic [MB_W-1:0]   mbytes;
    logic [MB_W-1:0]   bc_inc;
    logic              msg_end;
    logic [LEN2_W-1:0] len2;
    logic [7:0]        cbits;
    logic [7:0]        tbits;
    logic [3:0]        shift;
    logic [7:0]        pos_full;

    assign cfg_ready = 1'b1;
    assign q_push    = push && !q_full;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lws_reg <= 2'd2;
            mb_reg  <= 7'd32;
            cd_reg  <= 5'd3;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LOG_W_SELECT:    lws_reg <= cfg_data[1:0];
                CFG_MESSAGE_BYTES:   mb_reg  <= cfg_data;
                CFG_CHECKSUM_DIGITS: cd_reg  <= cfg_data[LEN2_W-1:0];
                default:             ;
            endcase
        end
    end

    // checksum gain of one byte: w-1-d per digit is the digit sum of the inverted byte
    always_comb
    begin
        nb = ~msg_byte;
        unique case (lws_reg)
            2'd0: inc = 16'(nb[0]) + 16'(nb[1]) + 16'(nb[2]) + 16'(nb[3])
                      + 16'(nb[4]) + 16'(nb[5]) + 16'(nb[6]) + 16'(nb[7]);
            2'd1: inc = 16'(nb[7:6]) + 16'(nb[5:4]) + 16'(nb[3:2]) + 16'(nb[1:0]);
            2'd2: inc = 16'(nb[7:4]) + 16'(nb[3:0]);
            default: inc = 16'(nb);
        endcase
    end

    // message end and checksum layout
    always_comb
    begin
        cs_sum   = cs_reg + inc;
        mbytes   = (mb_reg == '0) ? 7'd1 : mb_reg;
        bc_inc   = bc_reg + 7'd1;
        msg_end  = (bc_inc >= mbytes);
        len2     = (cd_reg == '0) ? 5'd1 :
                   ((cd_reg > 5'(LEN2_MAX)) ? 5'(LEN2_MAX) : cd_reg);
        cbits    = {3'b000, len2} << lws_reg;
        tbits    = (cbits + 8'(BYTE_ROUND)) & 8'hF8;
        shift    = 4'(BYTE_W) - {1'b0, cbits[2:0]};
        pos_full = tbits - {4'b0000, digit_bits(lws_reg)};

        q_entry.data     = msg_byte;
        q_entry.lws      = lws_reg;
        q_entry.msg_end  = msg_end;
        q_entry.len2     = len2;
        q_entry.csum_win = {8'h00, cs_sum} << shift;
        q_entry.pos      = pos_full[POS_W-1:0];

        bc_next = bc_reg;
        cs_next = cs_reg;
        if (q_push)
        begin
            bc_next = msg_end ? '0 : bc_inc;
            cs_next = msg_end ? '0 : cs_sum;
        end
    end

    // running counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg <= '0;
            cs_reg <= '0;
        end
        else
        begin
            bc_reg <= bc_next;
            cs_reg <= cs_next;
        end
    end

endmodule

// ===== rtl/wcl_queue.sv =====
// short queue of classified bytes between front and back
// depends on wcl_pkg
module wcl_queue
    import wcl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  wcl_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       valid,
    output wcl_entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    wcl_entry_t        mem [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign head    = mem[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // pointer and fill count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_entry;
    end

endmodule

// ===== rtl/wcl_back.sv =====
// back end: emits message digits then checksum digits, one per cycle while the receiver pops, into an output register
// depends on wcl_pkg
module wcl_back
    import wcl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  wcl_entry_t       q_head,
    output logic             q_pop,
    output logic [7:0]       digit,
    output logic [IDX_W-1:0] chain_index,
    output logic             is_checksum,
    output logic             last_digit,
    output logic             empty,
    input  logic             pop
);

    logic              busy_reg, busy_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  dcount_reg, dcount_next;
    logic [7:0]        sr_reg;
    logic [1:0]        lws_reg;
    logic              end_reg;
    logic [LEN2_W-1:0] cs_left_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [3:0]        msg_left_reg;
    logic [7:0]        digit_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              is_cs_reg;
    logic              last_reg;

    logic              adv;
    logic              in_msg;
    logic              entry_done;
    logic              take;
    logic              cs_last;
    logic [3:0]        lw;
    logic [7:0]        msg_dig;
    logic [7:0]        cs_dig;
    logic [WIN_W-1:0]  win_sh;

    assign digit       = digit_reg;
    assign chain_index = idx_reg;
    assign is_checksum = is_cs_reg;
    assign last_digit  = last_reg;
    assign empty       = !out_valid_reg;
    assign q_pop       = take;

    // digit selection and sequencing
    always_comb
    begin
        lw         = digit_bits(lws_reg);
        adv        = busy_reg && (!out_valid_reg || pop);
        in_msg     = (msg_left_reg != '0);
        cs_last    = !in_msg && (cs_left_reg == 5'd1);
        entry_done = in_msg ? ((msg_left_reg == 4'd1) && !end_reg) : cs_last;
        take       = (!busy_reg || (adv && entry_done)) && q_valid;

        unique case (lws_reg)
            2'd0: msg_dig = {7'b0, sr_reg[7]};
            2'd1: msg_dig = {6'b0, sr_reg[7:6]};
            2'd2: msg_dig = {4'b0, sr_reg[7:4]};
            default: msg_dig = sr_reg;
        endcase

        win_sh = win_reg >> pos_reg[4:0];
        cs_dig = (pos_reg >= POS_W'(WIN_W)) ? 8'h00 : (win_sh[7:0] & digit_mask(lws_reg));

        busy_next = busy_reg;
        if (take)
            busy_next = 1'b1;
        else if (adv && entry_done)
            busy_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;

        dcount_next = dcount_reg;
        if (adv)
            dcount_next = cs_last ? '0 : dcount_reg + 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            dcount_reg    <= '0;
            msg_left_reg  <= '0;
            cs_left_reg   <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            dcount_reg    <= dcount_next;
            if (take)
            begin
                msg_left_reg <= 4'd8 >> q_head.lws;
                cs_left_reg  <= q_head.len2;
            end
            else if (adv && !entry_done)
            begin
                if (in_msg)
                    msg_left_reg <= msg_left_reg - 1'b1;
                else
                    cs_left_reg <= cs_left_reg - 1'b1;
            end
        end
    end

    // current entry payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sr_reg  <= q_head.data;
            lws_reg <= q_head.lws;
            end_reg <= q_head.msg_end;
            win_reg <= q_head.csum_win;
            pos_reg <= q_head.pos;
        end
        else if (adv && !entry_done)
        begin
            if (in_msg)
                sr_reg <= sr_reg << lw;
            else
                pos_reg <= pos_reg - POS_W'(lw);
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            digit_reg <= in_msg ? msg_dig : cs_dig;
            idx_reg   <= dcount_reg;
            is_cs_reg <= !in_msg;
            last_reg  <= cs_last;
        end
    end

endmodule

// ===== rtl/wots_chain_length_digits_unit.sv =====
// Base-w digit generator for WOTS+ chain lengths with checksum digits appended per message.
// Digits leave one per cycle while the receiver keeps popping: a byte yields 8 >> log_w_select
// digits, and the last byte of a message also its checksum digits (one to sixteen). A byte passes
// through the queue, the emitter's entry registers and its output register before its first digit
// can be popped. The digit emitter, not the intake, limits how fast bytes are taken in.
// Depends on wcl_pkg, wcl_front, wcl_queue and wcl_back.
module wots_chain_length_digits_unit
    import wcl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [MB_W-1:0]  cfg_data,
    input  logic [7:0]       msg_byte,
    input  logic             push,
    output logic             full,
    output logic [7:0]       digit,
    output logic [IDX_W-1:0] chain_index,
    output logic             is_checksum,
    output logic             last_digit,
    output logic             empty,
    input  logic             pop
);

    wcl_entry_t q_in;
    wcl_entry_t q_head;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;

    // byte intake and classification
    wcl_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .msg_byte  (msg_byte),
        .push      (push),
        .q_full    (full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    // decoupling queue
    wcl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    // digit emission
    wcl_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .digit       (digit),
        .chain_index (chain_index),
        .is_checksum (is_checksum),
        .last_digit  (last_digit),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

// ===== rtl/wcl_checker.sv =====
// port-level checks on the result side of the chain length digit unit
// depends on wcl_pkg and wots_chain_length_digits_unit_defines.svh; bound to the top level
`include "wots_chain_length_digits_unit_defines.svh"

module wcl_checker
    import wcl_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic [7:0]       digit,
    input logic [IDX_W-1:0] chain_index,
    input logic             is_checksum,
    input logic             last_digit,
    input logic             empty,
    input logic             pop
);

    // the final digit of a message is always a checksum digit
    `WCL_ASSERT_IMPL(a_last_is_csum, !empty && last_digit, is_checksum, "last digit outside checksum")

    // checksum digits follow each other without a gap
    `WCL_ASSERT_NEXT(a_csum_no_gap, !empty && pop && is_checksum && !last_digit, !empty && is_checksum, "gap in checksum digits")

    // a new message restarts the index at zero
    `WCL_ASSERT_NEXT(a_index_restart, !empty && pop && last_digit, empty || chain_index == '0, "index not restarted")

    // within a message the index steps by one
    `WCL_ASSERT_NEXT(a_index_step, !empty && pop && !last_digit, empty || chain_index == IDX_W'($past(chain_index) + 1'b1), "index skipped")

    // a waiting transaction holds its payload
    `WCL_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(digit) && $stable(chain_index), "result changed while waiting")

endmodule

bind wots_chain_length_digits_unit wcl_checker u_wcl_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .digit       (digit),
    .chain_index (chain_index),
    .is_checksum (is_checksum),
    .last_digit  (last_digit),
    .empty       (empty),
    .pop         (pop)
);

// ===== bench/wots_chain_length_digits_checker.sv =====
`timescale 1ns / 100ps
// checker for the base-w chain length digit unit: follows config, byte and digit transactions
// predicts digits and checksum digits and compares them; depends on wcl_pkg
module wots_chain_length_digits_checker
    import wcl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [MB_W-1:0]  cfg_data,
    input  logic [7:0]       msg_byte,
    input  logic             push,
    input  logic             full,
    input  logic [7:0]       digit,
    input  logic [IDX_W-1:0] chain_index,
    input  logic             is_checksum,
    input  logic             last_digit,
    input  logic             empty,
    input  logic             pop,
    output int               pending,
    output int               errors
);

    typedef struct packed {
        logic [7:0]       value;
        logic [IDX_W-1:0] index;
        logic             cs;
        logic             last;
    } chain_digit_t;

    // digits still owed by the block, oldest first
    chain_digit_t expected_digits[$];

    // register copies
    logic [1:0]        sel_w;
    logic [MB_W-1:0]   msg_len;
    logic [LEN2_W-1:0] cs_len;

    // running message state
    logic [CS_W-1:0]   csum;
    logic [MB_W-1:0]   bytes_seen;
    logic [IDX_W-1:0]  digit_pos;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        errors++;
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic owe_digit(input logic [7:0] v, input logic cs, input logic last);
        chain_digit_t r;
        r.value = v;
        r.index = digit_pos;
        r.cs    = cs;
        r.last  = last;
        expected_digits.push_back(r);
        digit_pos = digit_pos + 1'b1;
    endtask

    // split one byte into digits, and close the message with its checksum digits
    task automatic predict_digits(input logic [7:0] b);
        int           log_w;
        int           per_byte;
        int           eff_bytes;
        int           len2;
        int           cbits;
        int           tbits;
        int           shift;
        int           p;
        int           i;
        logic [7:0]   dmask;
        logic [7:0]   d;
        logic [127:0] window;
        logic [127:0] part;
        log_w     = 1 << sel_w;
        dmask     = (1 << log_w) - 1;
        per_byte  = BYTE_W / log_w;
        eff_bytes = (msg_len == 0) ? 1 : msg_len;
        len2      = (cs_len == 0) ? 1 : ((cs_len > LEN2_MAX) ? LEN2_MAX : cs_len);

        // message digits, most significant first
        for (i = 0; i < per_byte; i++)
        begin
            d    = (b >> (BYTE_W - (i + 1) * log_w)) & dmask;
            csum = csum + (dmask - d);
            owe_digit(d, 1'b0, 1'b0);
        end
        bytes_seen = bytes_seen + 1'b1;

        // checksum digits after the last byte
        if (bytes_seen >= eff_bytes)
        begin
            cbits  = len2 * log_w;
            tbits  = ((cbits + BYTE_ROUND) / BYTE_W) * BYTE_W;
            shift  = BYTE_W - (cbits % BYTE_W);
            window = {112'd0, csum};
            window = window << shift;
            if (tbits < 128)
                window = window & ((128'd1 << tbits) - 1);
            for (i = 0; i < len2; i++)
            begin
                p    = tbits - (i + 1) * log_w;
                part = window >> p;
                d    = part[7:0] & dmask;
                owe_digit(d, 1'b1, (i + 1 == len2));
            end
            csum       = '0;
            bytes_seen = '0;
            digit_pos  = '0;
        end
    endtask

    task automatic check_digit();
        chain_digit_t want;
        if (expected_digits.size() == 0)
        begin
            report_mismatch("digit with nothing owed", -1, digit);
        end
        else
        begin
            want = expected_digits.pop_front();
            if (digit !== want.value)
                report_mismatch("digit", want.value, digit);
            if (chain_index !== want.index)
                report_mismatch("chain_index", want.index, chain_index);
            if (is_checksum !== want.cs)
                report_mismatch("is_checksum", want.cs, is_checksum);
            if (last_digit !== want.last)
                report_mismatch("last_digit", want.last, last_digit);
        end
    endtask

    // follow every transaction at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_w      = 2'd2;
            msg_len    = 7'd32;
            cs_len     = 5'd3;
            csum       = '0;
            bytes_seen = '0;
            digit_pos  = '0;
            expected_digits.delete();
        end
        else
        begin
            // register write transaction
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LOG_W_SELECT:    sel_w   = cfg_data[1:0];
                    CFG_MESSAGE_BYTES:   msg_len = cfg_data[MB_W-1:0];
                    CFG_CHECKSUM_DIGITS: cs_len  = cfg_data[LEN2_W-1:0];
                    default: ;
                endcase
            end
            // byte transaction
            if (push && !full)
                predict_digits(msg_byte);
            // digit transaction
            if (pop && !empty)
                check_digit();
        end
        pending <= expected_digits.size();
    end

endmodule

// ===== bench/wots_chain_length_digits_unit_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the base-w chain length digit unit: clock, reset, byte and register stimulus
// depends on wcl_pkg, the unit and wots_chain_length_digits_checker
module wots_chain_length_digits_unit_tb;
    import wcl_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index = CFG_LOG_W_SELECT;
    logic [MB_W-1:0]  cfg_data = '0;
    logic [7:0]       msg_byte = 8'd0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       digit;
    logic [IDX_W-1:0] chain_index;
    logic             is_checksum;
    logic             last_digit;
    logic             empty;
    logic             pop = 1'b0;

    int               pending;
    int               mismatches;

    // stimulus bookkeeping
    int               cur_len = 32;
    int               random_sent;
    int               phase;
    int               eff;
    int               count;
    bit               gaps_on = 1'b0;

    // receiver pattern
    int               stall_left = 0;
    int               mode_cycles = 0;
    int               sink_mode = 0;

    always #10 clk = ~clk;

    wots_chain_length_digits_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .msg_byte    (msg_byte),
        .push        (push),
        .full        (full),
        .digit       (digit),
        .chain_index (chain_index),
        .is_checksum (is_checksum),
        .last_digit  (last_digit),
        .empty       (empty),
        .pop         (pop)
    );

    wots_chain_length_digits_checker digit_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .msg_byte    (msg_byte),
        .push        (push),
        .full        (full),
        .digit       (digit),
        .chain_index (chain_index),
        .is_checksum (is_checksum),
        .last_digit  (last_digit),
        .empty       (empty),
        .pop         (pop),
        .pending     (pending),
        .errors      (mismatches)
    );

    // digit receiver: free-running, short random stalls, or long stalls
    always @(negedge clk)
    begin
        mode_cycles = mode_cycles + 1;
        if (mode_cycles == 300)
        begin
            mode_cycles = 0;
            sink_mode   = $urandom_range(0, 2);
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            pop <= 1'b0;
        end
        else if (sink_mode == 1 && $urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            pop <= 1'b0;
        end
        else if (sink_mode == 2 && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(4, 14);
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [MB_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MESSAGE_BYTES)
            cur_len = val;
    endtask

    // push stays high after acceptance so back-to-back bytes need no gap
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        push     <= 1'b1;
        msg_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic pause_push(input int n);
        repeat (n)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
    endtask

    // hold the sender until every owed digit has come out
    task automatic wait_drained();
        pause_push(1);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // bytes in bursts of random length, with gaps between bursts when enabled
    task automatic send_stream(input int n);
        int burst;
        int k;
        burst = 0;
        for (k = 0; k < n; k++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 16);
                if (gaps_on)
                    pause_push($urandom_range(1, 6));
            end
            send_byte(pick_byte());
            burst--;
        end
    endtask

    // random register setting for one phase, extremes weighted up
    task automatic pick_config();
        logic [MB_W-1:0] v;
        if ($urandom_range(0, 3) != 0)
        begin
            v = MB_W'($urandom_range(0, 3));
            if ($urandom_range(0, 5) == 0)
                v = v | MB_W'($urandom_range(0, 31) << 2);
            write_reg(CFG_LOG_W_SELECT, v);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            case ($urandom_range(0, 15))
                0:       v = 7'd0;
                1:       v = 7'd64;
                2:       v = MB_W'($urandom_range(65, 127));
                3:       v = 7'd32;
                default: v = MB_W'($urandom_range(1, 8));
            endcase
            write_reg(CFG_MESSAGE_BYTES, v);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            case ($urandom_range(0, 7))
                0:       v = 7'd0;
                1:       v = 7'd16;
                2:       v = MB_W'($urandom_range(17, 127));
                default: v = MB_W'($urandom_range(1, 16));
            endcase
            write_reg(CFG_CHECKSUM_DIGITS, v);
        end
        if ($urandom_range(0, 9) == 0)
            write_reg(CFG_SPARE, MB_W'($urandom_range(0, 127)));
    endtask

    // run limit
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset register values, message left open
        send_byte(8'h3C);
        send_byte(8'hFF);

        // w=2, message length zero, checksum length zero; open message closes at once
        wait_drained();
        write_reg(CFG_LOG_W_SELECT, 7'd0);
        write_reg(CFG_MESSAGE_BYTES, 7'd0);
        write_reg(CFG_CHECKSUM_DIGITS, 7'd0);
        write_reg(CFG_SPARE, 7'h7F);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);

        // w=256, one byte messages, checksum length saturating at sixteen
        wait_drained();
        write_reg(CFG_LOG_W_SELECT, 7'd3);
        write_reg(CFG_MESSAGE_BYTES, 7'd1);
        write_reg(CFG_CHECKSUM_DIGITS, 7'd31);
        send_byte(8'hFF);
        send_byte(8'h00);

        // w=4, two byte messages, sixteen checksum digits
        wait_drained();
        write_reg(CFG_LOG_W_SELECT, 7'd1);
        write_reg(CFG_MESSAGE_BYTES, 7'd2);
        write_reg(CFG_CHECKSUM_DIGITS, 7'd16);
        send_byte(8'h5A);
        send_byte(8'hC3);
        send_byte(8'h00);
        send_byte(8'hFF);

        // w=16, then shorten the message and change w part way through it
        wait_drained();
        write_reg(CFG_LOG_W_SELECT, 7'd2);
        write_reg(CFG_MESSAGE_BYTES, 7'd4);
        write_reg(CFG_CHECKSUM_DIGITS, 7'd3);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        wait_drained();
        write_reg(CFG_LOG_W_SELECT, 7'd1);
        write_reg(CFG_MESSAGE_BYTES, 7'd2);
        send_byte(8'h78);

        // random phases; the first is a long w=2 message whose chain index wraps
        random_sent = 0;
        phase       = 0;
        while (random_sent < 460)
        begin
            wait_drained();
            if (phase == 0)
            begin
                write_reg(CFG_LOG_W_SELECT, 7'd0);
                write_reg(CFG_MESSAGE_BYTES, 7'd127);
                write_reg(CFG_CHECKSUM_DIGITS, 7'd16);
            end
            else
            begin
                pick_config();
            end
            eff   = (cur_len == 0) ? 1 : cur_len;
            count = (eff > 16) ? eff : eff * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0)
                count = count + $urandom_range(1, eff);
            gaps_on = ($urandom_range(0, 3) != 0);
            send_stream(count);
            random_sent = random_sent + count;
            phase       = phase + 1;
        end

        // drain, then give the pipeline time to show anything stray
        wait_drained();
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
